>>> design/iprl_pkg.sv
package iprl_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = IDX_W + 1;

    // owner fetch tree: low index bits pick within a group, high bits pick the group
    localparam int PAD_W  = (IDX_W < 2) ? 2 : IDX_W;
    localparam int LO_W   = PAD_W / 2;
    localparam int HI_W   = PAD_W - LO_W;
    localparam int PAD_N  = 2 ** PAD_W;
    localparam int GRP_N  = 2 ** HI_W;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word low;
        t_word high;
        t_word owner;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_EXEC,
        TS_SEARCH,
        TS_DONE
    } t_top_state;

    typedef enum logic [1:0] {
        SR_IDLE,
        SR_STEP,
        SR_GRP,
        SR_SEL
    } t_srch_state;

    // per-cell strobes from the sequencer
    typedef struct packed {
        logic ins_en;
        logic cmp_en;
    } t_cell_ctl;

    // search outcome handed back to the sequencer
    typedef struct packed {
        logic  done;
        logic  found;
        t_word owner;
    } t_srch_res;

    function automatic t_word byte_reverse(input t_word v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

>>> design/iprl_cell.sv
module iprl_cell
    import iprl_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  logic      i_prev_keep,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  t_word     i_ip,
    output t_entry    o_entry,
    output logic      o_keep,
    output logic      o_lo_le,
    output logic      o_hi_ge
);

    t_entry r_entry;
    logic   r_lo_le;
    logic   r_hi_ge;

    // entry stays when it is live and sorts at or before the new low bound
    assign o_keep = i_valid && (r_entry.low <= i_new.low);

    // sorted insert: first non-kept cell takes the new entry, the rest shift along
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && !o_keep) begin
            r_entry <= i_prev_keep ? i_new : i_prev;
        end
    end

    // range compare against the lookup address
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lo_le <= (r_entry.low <= i_ip);
            r_hi_ge <= (r_entry.high >= i_ip);
        end
    end

    assign o_entry = r_entry;
    assign o_lo_le = r_lo_le;
    assign o_hi_ge = r_hi_ge;

endmodule

>>> design/iprl_search.sv
module iprl_search
    import iprl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [TABLE_DEPTH-1:0] i_lo_le,
    input  logic [TABLE_DEPTH-1:0] i_hi_ge,
    input  t_word                  i_owner [TABLE_DEPTH],
    output t_srch_res              o_res
);

    t_srch_state r_state;
    t_srch_state n_state;

    logic [CNT_W-1:0] r_l;
    logic [CNT_W-1:0] r_h;
    logic [IDX_W-1:0] r_idx;
    t_word            r_grp [GRP_N];
    logic             r_done;
    logic             r_found;
    t_word            r_owner;

    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_mid;
    logic [IDX_W-1:0] w_mid_idx;
    logic             w_live;
    logic             w_hit;
    logic [PAD_W-1:0] w_idx_pad;
    t_word            w_pad [PAD_N];

    // midpoint of the half-open interval [l, h)
    assign w_live    = (r_l < r_h);
    assign w_sum     = {1'b0, r_l} + {1'b0, r_h} - {{CNT_W{1'b0}}, 1'b1};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_mid_idx = w_mid[IDX_W-1:0];
    assign w_hit     = i_lo_le[w_mid_idx] && i_hi_ge[w_mid_idx];
    assign w_idx_pad = PAD_W'(r_idx);

    // owners padded out to a full power-of-two tree
    for (genvar p = 0; p < PAD_N; p++) begin : g_pad
        if (p < TABLE_DEPTH) begin : g_real
            assign w_pad[p] = i_owner[p];
        end else begin : g_fill
            assign w_pad[p] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SR_IDLE: begin
                if (i_start) n_state = SR_STEP;
            end
            SR_STEP: begin
                if (!w_live)    n_state = SR_IDLE;
                else if (w_hit) n_state = SR_GRP;
            end
            SR_GRP:  n_state = SR_SEL;
            SR_SEL:  n_state = SR_IDLE;
            default: n_state = SR_IDLE;
        endcase
    end

    // bisection bounds, one probe per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == SR_IDLE && i_start) begin
            r_l <= '0;
            r_h <= i_count;
        end else if (r_state == SR_STEP && w_live) begin
            if (w_hit) begin
                r_idx <= w_mid_idx;
            end else if (!i_lo_le[w_mid_idx]) begin
                r_h <= w_mid;
            end else begin
                r_l <= w_mid + {{(CNT_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // owner fetch, first level: one pick inside every group
    for (genvar g = 0; g < GRP_N; g++) begin : g_grp
        always_ff @(posedge i_clk) begin
            if (r_state == SR_GRP) begin
                r_grp[g] <= w_pad[{HI_W'(g), w_idx_pad[LO_W-1:0]}];
            end
        end
    end

    // result strobe: miss straight from the probe loop, hit after the fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == SR_STEP && !w_live) || (r_state == SR_SEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SR_SEL) begin
            r_found <= 1'b1;
            r_owner <= r_grp[w_idx_pad[PAD_W-1:LO_W]];
        end else if (r_state == SR_STEP && !w_live) begin
            r_found <= 1'b0;
            r_owner <= '0;
        end
    end

    assign o_res = '{done: r_done, found: r_found, owner: r_owner};

endmodule

>>> design/ip_range_lookup_top.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------------------
// input     | in        | i_valid / o_stall     | i_command, i_range_low, i_range_high,
//           |           |                       | i_owner_id, i_ip_address
// result    | out       | o_valid / i_stall     | o_found, o_match_owner, o_status
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (swap_byte_order)
//
// clear, insert and no-op pass the EXEC and DONE states before they load the output register;
// insert shifts the whole cell row at once.
// a lookup makes one probe per cycle against flags held in the cell row, at most
// log2 depth + 1 probes that land on an entry; a hit then passes the GRP and SEL fetch.
// reset (synchronous, active low) empties the table and sets byte swapping on.
// one transaction in flight; o_stall is high until its result enters the output
// register, and a result stalled there holds the next one back.
module ip_range_lookup_top
    import iprl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    input  logic [31:0] i_owner_id,
    input  logic [31:0] i_ip_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [31:0] o_match_owner,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    t_top_state r_state;
    t_top_state n_state;

    logic             r_swap;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_cmd;
    t_entry           r_new;
    t_word            r_ip;

    logic  r_res_found;
    t_word r_res_owner;
    logic [1:0] r_res_status;

    logic  r_out_valid;
    logic  r_out_found;
    t_word r_out_owner;
    logic [1:0] r_out_status;

    logic      w_accept;
    logic      w_out_free;
    logic      w_is_insert;
    logic      w_is_lookup;
    logic      w_bad;
    logic      w_full;
    t_cell_ctl w_ctl;
    t_srch_res w_srch;

    t_entry                 w_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_keep;
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_lo_le;
    logic [TABLE_DEPTH-1:0] w_hi_ge;
    t_word                  w_owner [TABLE_DEPTH];

    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_is_insert = (r_cmd == CMD_INSERT);
    assign w_is_lookup = (r_cmd == CMD_LOOKUP);
    assign w_bad       = (r_new.low > r_new.high);
    assign w_full      = (r_count >= CNT_W'(TABLE_DEPTH));

    // cell strobes
    assign w_ctl.ins_en = (r_state == TS_EXEC) && w_is_insert && !w_bad && !w_full;
    assign w_ctl.cmp_en = (r_state == TS_EXEC) && w_is_lookup;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_swap <= i_cfg_data;
        end
    end

    // capture of the accepted transaction, bounds and address byte-swapped on the way in when swapping is on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_command;
            r_new.low   <= r_swap ? byte_reverse(i_range_low)  : i_range_low;
            r_new.high  <= r_swap ? byte_reverse(i_range_high) : i_range_high;
            r_new.owner <= i_owner_id;
            r_ip        <= r_swap ? byte_reverse(i_ip_address) : i_ip_address;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: begin
                if (w_accept) n_state = TS_EXEC;
            end
            TS_EXEC: begin
                n_state = w_is_lookup ? TS_SEARCH : TS_DONE;
            end
            TS_SEARCH: begin
                if (w_srch.done) n_state = TS_DONE;
            end
            TS_DONE: begin
                if (w_out_free) n_state = TS_IDLE;
            end
            default: n_state = TS_IDLE;
        endcase
    end

    assign o_stall = (r_state != TS_IDLE);

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == TS_EXEC && r_cmd == CMD_CLEAR) begin
            r_count <= '0;
        end else if (w_ctl.ins_en) begin
            r_count <= r_count + {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (r_state == TS_EXEC) begin
            r_res_found <= 1'b0;
            r_res_owner <= '0;
            if (w_is_insert && w_bad) begin
                r_res_status <= STS_BAD;
            end else if (w_is_insert && w_full) begin
                r_res_status <= STS_FULL;
            end else begin
                r_res_status <= STS_OK;
            end
        end else if (r_state == TS_SEARCH && w_srch.done) begin
            r_res_found  <= w_srch.found;
            r_res_owner  <= w_srch.owner;
            r_res_status <= STS_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == TS_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == TS_DONE && w_out_free) begin
            r_out_found  <= r_res_found;
            r_out_owner  <= r_res_owner;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_owner = r_out_owner;
    assign o_status      = r_out_status;

    // row of table cells, cell 0 holds the smallest low bound
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_keep;

        if (i == 0) begin : g_head
            assign w_prev      = r_new;
            assign w_prev_keep = 1'b1;
        end else begin : g_body
            assign w_prev      = w_entry[i-1];
            assign w_prev_keep = w_keep[i-1];
        end

        assign w_valid[i] = (CNT_W'(i) < r_count);
        assign w_owner[i] = w_entry[i].owner;

        iprl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (w_valid[i]),
            .i_prev_keep (w_prev_keep),
            .i_new       (r_new),
            .i_prev      (w_prev),
            .i_ip        (r_ip),
            .o_entry     (w_entry[i]),
            .o_keep      (w_keep[i]),
            .o_lo_le     (w_lo_le[i]),
            .o_hi_ge     (w_hi_ge[i])
        );
    end

    iprl_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.cmp_en),
        .i_count (r_count),
        .i_lo_le (w_lo_le),
        .i_hi_ge (w_hi_ge),
        .i_owner (w_owner),
        .o_res   (w_srch)
    );

    // table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // search unit reports only while a lookup is waiting on it
    a_srch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_srch.done |-> (r_state == TS_SEARCH))
        else $error("search result outside lookup");

    // a successful insert adds exactly one entry
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins_en |=> (r_count == $past(r_count) + {{(CNT_W-1){1'b0}}, 1'b1}))
        else $error("insert did not grow the table by one");

    // a hit never carries an error status
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_status == STS_OK))
        else $error("hit reported with error status");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import iprl_pkg::*;
();

    // the command code that the block treats as a no-op
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct {
        logic [1:0] cmd;
        t_word      lo;
        t_word      hi;
        t_word      own;
        t_word      ip;
    } t_table_op;

    typedef struct {
        logic       found;
        t_word      owner;
        logic [1:0] status;
    } t_table_reply;

    // clock and block inputs, all known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_command    = 2'd0;
    logic [31:0] i_range_low  = 32'd0;
    logic [31:0] i_range_high = 32'd0;
    logic [31:0] i_owner_id   = 32'd0;
    logic [31:0] i_ip_address = 32'd0;
    logic        i_stall      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        i_cfg_data   = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_match_owner;
    logic [1:0]  o_status;
    logic        o_cfg_ready;

    // shadow of the range table and the swap setting
    t_word mdl_low   [TABLE_DEPTH];
    t_word mdl_high  [TABLE_DEPTH];
    t_word mdl_owner [TABLE_DEPTH];
    int    mdl_count = 0;
    logic  mdl_swap  = 1'b1;

    // transaction queues and bookkeeping
    t_table_op    pending_ops[$];
    t_table_reply expected_replies[$];
    t_table_op    current_op;
    t_table_reply want_reply;
    t_word        known_lo[$];
    t_word        known_hi[$];

    int   ops_queued     = 0;
    int   ops_accepted   = 0;
    int   replies_seen   = 0;
    int   mismatches     = 0;
    int   swap_writes    = 0;
    int   hits           = 0;
    int   misses         = 0;
    int   full_rejects   = 0;
    int   bound_rejects  = 0;
    int   deepest        = 0;
    int   quiet_cycles   = 0;
    logic calm           = 1'b0;

    ip_range_lookup_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_owner_id    (i_owner_id),
        .i_ip_address  (i_ip_address),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_match_owner (o_match_owner),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // reverse the four bytes of a word
    function automatic t_word flip_bytes(input t_word v);
        t_word r;
        int k;
        for (k = 0; k < 4; k++) begin
            r[8*k +: 8] = v[8*(3-k) +: 8];
        end
        return r;
    endfunction

    // form of a logical address as it goes on the wire under the current setting
    function automatic t_word on_wire(input t_word v);
        return mdl_swap ? flip_bytes(v) : v;
    endfunction

    // apply one transaction to the shadow table and return the result it gives
    function automatic t_table_reply predict_reply(input t_table_op op);
        t_table_reply rep;
        t_word lo, hi, ip;
        int pos, k, l, r, mid;
        rep = '{1'b0, 32'd0, STS_OK};
        lo = on_wire(op.lo);
        hi = on_wire(op.hi);
        ip = on_wire(op.ip);
        case (op.cmd)
            CMD_CLEAR: begin
                mdl_count = 0;
            end
            CMD_INSERT: begin
                if (lo > hi) begin
                    rep.status = STS_BAD;
                    bound_rejects++;
                end else if (mdl_count >= TABLE_DEPTH) begin
                    rep.status = STS_FULL;
                    full_rejects++;
                end else begin
                    // new entry goes after every entry with a low bound not above it
                    pos = 0;
                    while (pos < mdl_count && mdl_low[pos] <= lo) pos++;
                    for (k = mdl_count; k > pos; k--) begin
                        mdl_low[k]   = mdl_low[k-1];
                        mdl_high[k]  = mdl_high[k-1];
                        mdl_owner[k] = mdl_owner[k-1];
                    end
                    mdl_low[pos]   = lo;
                    mdl_high[pos]  = hi;
                    mdl_owner[pos] = op.own;
                    mdl_count++;
                    if (mdl_count > deepest) deepest = mdl_count;
                end
            end
            CMD_LOOKUP: begin
                // bisection exactly as the block does it, overlaps included
                l = 0;
                r = mdl_count - 1;
                while (l <= r && !rep.found) begin
                    mid = (l + r) / 2;
                    if (mdl_low[mid] <= ip && ip <= mdl_high[mid]) begin
                        rep.found = 1'b1;
                        rep.owner = mdl_owner[mid];
                    end else if (mdl_low[mid] > ip) begin
                        r = mid - 1;
                    end else begin
                        l = mid + 1;
                    end
                end
                if (rep.found) hits++;
                else misses++;
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    // one line per mismatch
    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // stimulus helpers, raw and in logical address space
    task automatic push_op(input logic [1:0] cmd, input t_word lo, input t_word hi,
                           input t_word own, input t_word ip);
        t_table_op op;
        op = '{cmd, lo, hi, own, ip};
        pending_ops.insert(pending_ops.size(), op);
        ops_queued++;
    endtask

    task automatic add_range(input t_word lo, input t_word hi, input t_word own);
        push_op(CMD_INSERT, on_wire(lo), on_wire(hi), own, $urandom());
        if (lo <= hi) begin
            known_lo.insert(known_lo.size(), lo);
            known_hi.insert(known_hi.size(), hi);
        end
    endtask

    task automatic probe(input t_word ip);
        push_op(CMD_LOOKUP, $urandom(), $urandom(), $urandom(), on_wire(ip));
    endtask

    task automatic wipe_table();
        push_op(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
        known_lo.delete();
        known_hi.delete();
    endtask

    // lookup aimed inside or just around a range already inserted
    task automatic probe_known();
        int idx;
        t_word lo, hi, span;
        if (known_lo.size() == 0 || $urandom_range(0, 3) == 0) begin
            probe($urandom());
        end else begin
            idx  = $urandom_range(0, known_lo.size() - 1);
            lo   = known_lo[idx];
            hi   = known_hi[idx];
            span = hi - lo;
            case ($urandom_range(0, 4))
                0: probe(lo);
                1: probe(hi);
                2: probe(lo - 1);
                3: probe(hi + 1);
                default: probe((span == '1) ? t_word'($urandom()) : lo + $urandom() % (span + 1));
            endcase
        end
    endtask

    // mixed traffic: mostly well-formed inserts and lookups, some noise
    task automatic build_mixed(input int n);
        int k, pick;
        t_word lo, hi;
        wipe_table();
        for (k = 1; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                if (known_lo.size() != 0 && $urandom_range(0, 6) == 0)
                    lo = known_lo[$urandom_range(0, known_lo.size() - 1)];
                else
                    lo = $urandom();
                hi = lo + ($urandom() >> $urandom_range(2, 31));
                if (hi < lo) hi = '1;
                add_range(lo, hi, $urandom());
            end else if (pick < 46) begin
                lo = $urandom();
                if (lo == 0) lo = 1;
                add_range(lo, $urandom() % lo, $urandom());
            end else if (pick < 86) begin
                probe_known();
            end else if (pick < 89) begin
                wipe_table();
            end else if (pick < 95) begin
                push_op(CMD_NOP, $urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                push_op(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                        $urandom());
            end
        end
    endtask

    // fill the table to the brim with disjoint ranges in random order
    task automatic build_full();
        int order[TABLE_DEPTH];
        int k, j, tmp;
        t_word slot, lo;
        slot = 32'hffff_ffff / TABLE_DEPTH;
        wipe_table();
        for (k = 0; k < TABLE_DEPTH; k++) order[k] = k;
        for (k = TABLE_DEPTH - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < TABLE_DEPTH; k++) begin
            lo = t_word'(order[k]) * slot + $urandom() % (slot / 2);
            add_range(lo, lo + $urandom() % (slot / 2), $urandom());
            if ($urandom_range(0, 4) == 0) probe_known();
        end
        // table full, then bad bounds while full
        for (k = 0; k < 3; k++) add_range($urandom() >> 1, 32'hffff_fff0, $urandom());
        add_range(32'h8000_0000, 32'h7fff_ffff, $urandom());
        probe(32'h0000_0000);
        probe(32'hffff_ffff);
        for (k = 0; k < 40; k++) probe_known();
    endtask

    // wait until every transaction is accepted and every result checked
    task automatic wait_idle();
        do @(posedge i_clk);
        while (ops_accepted != ops_queued || expected_replies.size() != 0);
    endtask

    // write the swap setting over the configuration channel
    task automatic write_swap(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mdl_swap = v;
        swap_writes++;
    endtask

    // input driver: one transaction at a time from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_replies.insert(expected_replies.size(), predict_reply(current_op));
                ops_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                    current_op = pending_ops[0];
                    pending_ops.delete(0);
                    i_valid      <= 1'b1;
                    i_command    <= current_op.cmd;
                    i_range_low  <= current_op.lo;
                    i_range_high <= current_op.hi;
                    i_owner_id   <= current_op.own;
                    i_ip_address <= current_op.ip;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_replies.size() == 0) begin
                    flag_mismatch($sformatf("result with none pending: found %0b owner %h status %0d",
                                            o_found, o_match_owner, o_status));
                end else begin
                    want_reply = expected_replies[0];
                    expected_replies.delete(0);
                    replies_seen++;
                    if (o_found !== want_reply.found)
                        flag_mismatch($sformatf("result %0d found %0b, want %0b",
                                                replies_seen, o_found, want_reply.found));
                    if (o_match_owner !== want_reply.owner)
                        flag_mismatch($sformatf("result %0d owner %h, want %h",
                                                replies_seen, o_match_owner, want_reply.owner));
                    if (o_status !== want_reply.status)
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                replies_seen, o_status, want_reply.status));
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 29);
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // run sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_swap(1'b1);

        // directed: empty table, extremes, equal lows, overlaps, bad bounds, no-op
        probe(32'h0000_0000);
        probe(32'hffff_ffff);
        push_op(CMD_NOP, '1, '1, '1, '1);
        add_range(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_range(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_range(32'h1000_0000, 32'h1000_ffff, 32'h0000_0011);
        add_range(32'h1000_0000, 32'h1000_0005, 32'h0000_0022);
        add_range(32'h0fff_0000, 32'h2000_0000, 32'h0000_0033);
        add_range(32'h0000_0002, 32'h0000_0001, 32'h0000_0055);
        // bounds that are only in order once the bytes are swapped
        push_op(CMD_INSERT, 32'h0100_0000, 32'h0000_0002, 32'h0000_0044, 32'h0);
        probe(32'h0000_0000);
        probe(32'hffff_ffff);
        probe(32'h1000_0003);
        probe(32'h1000_ffff);
        probe(32'h1001_0000);
        probe(32'h0fff_0000);
        probe(32'h3000_0000);
        probe(32'h7fff_ffff);
        wipe_table();
        probe(32'h1000_0003);
        add_range(32'h0000_0000, 32'hffff_ffff, 32'ha5a5_a5a5);
        probe(32'h8000_0000);
        push_op(CMD_NOP, '0, '0, '0, '0);
        wait_idle();

        // random phases over both settings, one without any idling
        write_swap(1'b0);
        build_mixed(320);
        wait_idle();
        write_swap(1'b1);
        calm = 1'b1;
        build_full();
        wait_idle();
        calm = 1'b0;
        write_swap(1'b0);
        build_mixed(200);
        wait_idle();
        write_swap(1'b1);
        build_mixed(200);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d transactions, %0d results checked, %0d swap setting writes",
                 ops_accepted, replies_seen, swap_writes);
        $display("run: %0d lookup hits, %0d misses, %0d full and %0d bad-bound rejects, %0d deep",
                 hits, misses, full_rejects, bound_rejects, deepest);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
